/* hw/rtl/utf8_to_utf16_unit_indexer_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer assertion macros
// Concurrent assertion wrappers that can be compiled out as a whole.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_UNIT_INDEXER_ASSERT_SVH
`define UTF8_TO_UTF16_UNIT_INDEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define U8U16_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");
`define U8U16_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_IMP(label, clk, rst, ante, cons)
`define U8U16_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer package
// Shared constants, the sequencer state type and the lead byte decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int INDEX_WIDTH_DEF = 16;

  localparam logic [7:0]  LEAD2_LO    = 8'hC2;
  localparam logic [7:0]  LEAD2_HI    = 8'hDF;
  localparam logic [7:0]  LEAD3_LO    = 8'hE0;
  localparam logic [7:0]  LEAD3_HI    = 8'hEF;
  localparam logic [7:0]  LEAD4_LO    = 8'hF0;
  localparam logic [7:0]  LEAD4_HI    = 8'hF4;
  localparam logic [15:0] MIN_THREE   = 16'h0800;
  localparam logic [15:0] SUR_LO      = 16'hD800;
  localparam logic [15:0] SUR_HI      = 16'hDFFF;
  localparam logic [20:0] MIN_FOUR    = 21'h010000;
  localparam logic [20:0] MAX_CP      = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [15:0] HI_SUR_BASE = 16'hD800;
  localparam logic [15:0] LO_SUR_BASE = 16'hDC00;
  localparam logic [7:0]  CONT_TAG    = 8'h80;
  localparam logic [7:0]  THREE_TAG   = 8'hE0;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  function automatic logic [2:0] seq_length(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd1;
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) begin
      len = 3'd2;
    end else if (lead >= LEAD3_LO && lead <= LEAD3_HI) begin
      len = 3'd3;
    end else if (lead >= LEAD4_LO && lead <= LEAD4_HI) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

/* hw/rtl/u8u16_ifs.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer channels
// Byte input channel and character result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8u16_in_if
  import u8u16_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   last_byte;
  logic [INDEX_WIDTH-1:0] target_index;

  modport source (output valid, output data_byte, output last_byte,
                  output target_index, input ready);
  modport sink (input valid, input data_byte, input last_byte,
                input target_index, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [20:0]            char_value;
  logic [2:0]             byte_width;
  logic [1:0]             unit_count;
  logic [INDEX_WIDTH-1:0] unit_offset;
  logic                   hit;
  logic [31:0]            hit_bytes;
  logic [2:0]             hit_length;
  logic [INDEX_WIDTH-1:0] total_units;
  logic                   last_result;

  modport source (output valid, output char_value, output byte_width,
                  output unit_count, output unit_offset, output hit,
                  output hit_bytes, output hit_length, output total_units,
                  output last_result, input ready);
  modport sink (input valid, input char_value, input byte_width,
                input unit_count, input unit_offset, input hit,
                input hit_bytes, input hit_length, input total_units,
                input last_result, output ready);
endinterface

/* hw/rtl/utf8_to_utf16_unit_indexer.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer
// Strict UTF-8 decoder that reports UTF-16 offsets and the character that
// covers a wanted UTF-16 index.
//
// Bytes of a string arrive one word at a time on byte_in; last_byte closes
// the string and target_index is sampled on its first byte. Each decoded
// character leaves as one word on char_out with its code point, widths,
// starting unit offset, the hit flag with its bytes or CESU-8 surrogate half,
// and on the final character the total unit count.
// A byte is taken only while the sequencer is idle. After a byte is taken,
// one shared decode unit examines the held bytes once per cycle and, while
// the output register has room, releases one character per cycle, then closes
// the scan and returns to idle; a byte releases n characters, n from 0 to 4.
// The byte that completes a result is registered into the held bytes, and the character then into the output register.
// A stalled receiver holds the output register and the decode unit waits
// on it; no byte is taken until every pending character has reached the
// output register.
// Synchronous reset clears the sequencer, the held byte count, the running
// offset and the output valid; the held bytes themselves are not cleared.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_unit_indexer_assert.svh"

module utf8_to_utf16_unit_indexer
  import u8u16_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  u8u16_in_if.sink    byte_in,
  u8u16_out_if.source char_out
);

  localparam logic [INDEX_WIDTH+1:0] POS_LIMIT = {2'b01, {INDEX_WIDTH{1'b0}}};

  state_t state, state_next;

  logic [7:0]             held [4];
  logic [7:0]             held_shift [4];
  logic [2:0]             held_count;
  logic [INDEX_WIDTH:0]   unit_position;
  logic [INDEX_WIDTH-1:0] wanted_index;
  logic                   inside_string;
  logic                   last_flag;

  logic                   res_valid;
  logic [20:0]            res_char_value;
  logic [2:0]             res_byte_width;
  logic [1:0]             res_unit_count;
  logic [INDEX_WIDTH-1:0] res_unit_offset;
  logic                   res_hit;
  logic [31:0]            res_hit_bytes;
  logic [2:0]             res_hit_length;
  logic [INDEX_WIDTH-1:0] res_total_units;
  logic                   res_last;

  logic                   accept;
  logic                   scanning;
  logic                   slot_free;
  logic                   do_emit;
  logic                   done;

  logic [7:0]             lead;
  logic [2:0]             need;
  logic [2:0]             have;
  logic                   ok;
  logic                   complete;
  logic                   waiting;
  logic [20:0]            v2;
  logic [15:0]            v3;
  logic [20:0]            v4;
  logic                   value_ok;
  logic [20:0]            value;
  logic [2:0]             take;
  logic [20:0]            cp;
  logic [1:0]             units;
  logic [INDEX_WIDTH+1:0] end_sum;
  logic [INDEX_WIDTH:0]   position_next;
  logic                   hit;
  logic                   final_char;
  logic [20:0]            cp_off;
  logic [15:0]            sur;
  logic [31:0]            packed_bytes;
  logic [2:0]             packed_len;
  logic [INDEX_WIDTH-1:0] offset_sat;
  logic [INDEX_WIDTH-1:0] total_sat;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    byte_in.ready = 1'b0;
    scanning      = 1'b0;
    unique case (state)
      ST_IDLE: byte_in.ready = 1'b1;
      ST_SCAN: scanning = 1'b1;
      default: byte_in.ready = 1'b0;
    endcase
  end

  assign accept    = byte_in.valid && byte_in.ready;
  assign slot_free = !res_valid || char_out.ready;

  always_comb begin
    lead     = held[0];
    need     = seq_length(lead);
    have     = (held_count < need) ? held_count : need;
    ok       = !((have >= 3'd2) && (held[1][7:6] != CONT_TAG[7:6])) &&
               !((have >= 3'd3) && (held[2][7:6] != CONT_TAG[7:6])) &&
               !((have >= 3'd4) && (held[3][7:6] != CONT_TAG[7:6]));
    complete = held_count >= need;
    waiting  = (need > 3'd1) && ok && !complete && !last_flag;

    v2 = {10'd0, lead[4:0], held[1][5:0]};
    v3 = {lead[3:0], held[1][5:0], held[2][5:0]};
    v4 = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
    case (need)
      3'd2: begin
        value    = v2;
        value_ok = 1'b1;
      end
      3'd3: begin
        value    = {5'd0, v3};
        value_ok = (v3 >= MIN_THREE) && !((v3 >= SUR_LO) && (v3 <= SUR_HI));
      end
      3'd4: begin
        value    = v4;
        value_ok = (v4 >= MIN_FOUR) && (v4 <= MAX_CP);
      end
      default: begin
        value    = {13'd0, lead};
        value_ok = 1'b0;
      end
    endcase

    if ((need > 3'd1) && ok && complete && value_ok) begin
      take = need;
      cp   = value;
    end else begin
      take = 3'd1;
      cp   = {13'd0, lead};
    end

    units   = (cp > BMP_MAX) ? 2'd2 : 2'd1;
    end_sum = {1'b0, unit_position} + {{INDEX_WIDTH{1'b0}}, units};
    hit     = ({1'b0, wanted_index} >= unit_position) &&
              ({2'b00, wanted_index} < end_sum);
    position_next = (end_sum > POS_LIMIT) ? POS_LIMIT[INDEX_WIDTH:0]
                                          : end_sum[INDEX_WIDTH:0];
    final_char = last_flag && (held_count == take);
    offset_sat = unit_position[INDEX_WIDTH] ? {INDEX_WIDTH{1'b1}}
                                            : unit_position[INDEX_WIDTH-1:0];
    total_sat  = position_next[INDEX_WIDTH] ? {INDEX_WIDTH{1'b1}}
                                            : position_next[INDEX_WIDTH-1:0];

    cp_off = cp - MIN_FOUR;
    if ({1'b0, wanted_index} == unit_position) begin
      sur = HI_SUR_BASE + {6'd0, cp_off[19:10]};
    end else begin
      sur = LO_SUR_BASE + {6'd0, cp_off[9:0]};
    end

    packed_bytes = 32'd0;
    packed_len   = 3'd0;
    if (hit) begin
      if (units == 2'd2) begin
        packed_bytes = {8'd0, CONT_TAG | {2'b00, sur[5:0]},
                        CONT_TAG | {2'b00, sur[11:6]}, THREE_TAG | {4'd0, sur[15:12]}};
        packed_len   = 3'd3;
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < take) begin
            packed_bytes[8*i +: 8] = held[i];
          end
        end
        packed_len = take;
      end
    end
  end

  always_comb begin
    held_shift[0] = held[1];
    held_shift[1] = held[2];
    held_shift[2] = held[3];
    held_shift[3] = held[3];
    case (take)
      3'd2: begin
        held_shift[0] = held[2];
        held_shift[1] = held[3];
      end
      3'd3: held_shift[0] = held[3];
      default: held_shift[0] = held[1];
    endcase
  end

  assign do_emit = scanning && (held_count != 3'd0) && !waiting && slot_free;
  assign done    = scanning && ((held_count == 3'd0) || waiting);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        if (held_count[1:0] == 2'(i)) begin
          held[i] <= byte_in.data_byte;
        end
      end
    end else if (do_emit) begin
      held <= held_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_count    <= 3'd0;
      unit_position <= '0;
      wanted_index  <= '0;
      inside_string <= 1'b0;
      last_flag     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        held_count <= held_count + 3'd1;
        last_flag  <= byte_in.last_byte;
        if (!inside_string) begin
          wanted_index  <= byte_in.target_index;
          unit_position <= '0;
          inside_string <= 1'b1;
        end
      end else if (do_emit) begin
        held_count    <= held_count - take;
        unit_position <= position_next;
      end else if (done && last_flag) begin
        held_count    <= 3'd0;
        unit_position <= '0;
        inside_string <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_emit) begin
      res_valid <= 1'b1;
    end else if (char_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      res_char_value  <= cp;
      res_byte_width  <= take;
      res_unit_count  <= units;
      res_unit_offset <= offset_sat;
      res_hit         <= hit;
      res_hit_bytes   <= packed_bytes;
      res_hit_length  <= packed_len;
      res_total_units <= final_char ? total_sat : '0;
      res_last        <= final_char;
    end
  end

  assign char_out.valid       = res_valid;
  assign char_out.char_value  = res_char_value;
  assign char_out.byte_width  = res_byte_width;
  assign char_out.unit_count  = res_unit_count;
  assign char_out.unit_offset = res_unit_offset;
  assign char_out.hit         = res_hit;
  assign char_out.hit_bytes   = res_hit_bytes;
  assign char_out.hit_length  = res_hit_length;
  assign char_out.total_units = res_total_units;
  assign char_out.last_result = res_last;

  `U8U16_ASSERT_IMP(a_accept_room, clk, rst, accept, held_count <= 3'd3)
  `U8U16_ASSERT_IMP(a_hit_length, clk, rst, res_valid && res_hit, (res_hit_length == 3'd3) || (res_hit_length == res_byte_width))
  `U8U16_ASSERT_IMP(a_miss_empty, clk, rst, res_valid && !res_hit, (res_hit_length == 3'd0) && (res_hit_bytes == 32'd0))
  `U8U16_ASSERT_IMP(a_idle_clear, clk, rst, (state == ST_IDLE) && !inside_string, (held_count == 3'd0) && (unit_position == '0))
  `U8U16_ASSERT_NXT(a_emit_valid, clk, rst, do_emit, res_valid)

endmodule

/* dv/utf8_to_utf16_unit_indexer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer checker
// Watches the byte and character channels. Every accepted byte is run through
// a local strict UTF-8 decoder with its own held bytes and unit offset, which
// queues the character words that byte should release. Each accepted
// character word is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module utf8_to_utf16_unit_indexer_checker
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8u16_in_if         byte_in,
  u8u16_out_if        char_out,
  output int unsigned mismatches,
  output int unsigned chars_pending,
  output int unsigned chars_checked,
  output int unsigned hits_seen
);

  localparam int IW = INDEX_WIDTH_DEF;
  localparam longint unsigned POS_LIMIT = 64'd1 << IW;
  localparam longint unsigned POS_MAX = POS_LIMIT - 64'd1;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [20:0] SUR_INDEX_MASK = 21'h0003FF;

  typedef struct packed {
    logic [20:0]   char_value;
    logic [2:0]    byte_width;
    logic [1:0]    unit_count;
    logic [IW-1:0] unit_offset;
    logic          hit;
    logic [31:0]   hit_bytes;
    logic [2:0]    hit_length;
    logic [IW-1:0] total_units;
    logic          last_result;
  } char_word_t;

  logic [7:0]        held [4];
  int unsigned       held_n;
  longint unsigned   unit_pos;
  longint unsigned   wanted;
  bit                in_string;
  char_word_t        char_expect_q [$];
  int unsigned       err_n;
  int unsigned       checked_n;
  int unsigned       hit_n;

  function automatic int unsigned lead_span(input logic [7:0] lead);
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) begin
      return 2;
    end
    if (lead >= LEAD3_LO && lead <= LEAD3_HI) begin
      return 3;
    end
    if (lead >= LEAD4_LO && lead <= LEAD4_HI) begin
      return 4;
    end
    return 1;
  endfunction

  task automatic predict_char(input logic [20:0] cp, input int unsigned width,
                              input bit closing);
    char_word_t      w;
    longint unsigned units;
    longint unsigned start;
    longint unsigned stop;
    logic [20:0]     rel;
    logic [15:0]     sur;
    bit              hit;
    w = '0;
    units = (cp > BMP_MAX) ? 2 : 1;
    start = unit_pos;
    stop = start + units;
    hit = (wanted >= start) && (wanted < stop);
    if (hit) begin
      if (units == 1) begin
        for (int i = 0; i < width && i < 4; i++) begin
          w.hit_bytes[8*i +: 8] = held[i];
        end
        w.hit_length = 3'(width);
      end else begin
        rel = cp - MIN_FOUR;
        sur = (wanted == start) ? HI_SUR_BASE + 16'(rel >> 10)
                                : LO_SUR_BASE + 16'(rel & SUR_INDEX_MASK);
        w.hit_bytes = {8'h00, CONT_TAG | {2'b00, sur[5:0]},
                       CONT_TAG | {2'b00, sur[11:6]}, THREE_TAG | {4'h0, sur[15:12]}};
        w.hit_length = 3'd3;
      end
    end
    unit_pos = (stop > POS_LIMIT) ? POS_LIMIT : stop;
    w.char_value = cp;
    w.byte_width = 3'(width);
    w.unit_count = 2'(units);
    w.unit_offset = IW'((start > POS_MAX) ? POS_MAX : start);
    w.hit = hit;
    w.total_units = closing ? IW'((unit_pos > POS_MAX) ? POS_MAX : unit_pos) : '0;
    w.last_result = closing;
    char_expect_q.push_back(w);
  endtask

  task automatic predict_byte(input logic [7:0] b, input bit lst,
                              input logic [IW-1:0] tgt);
    int unsigned n;
    int unsigned need;
    int unsigned take;
    int unsigned have;
    logic [7:0]  lead;
    logic [20:0] cp;
    logic [20:0] v;
    bit          ok;
    bit          good;
    if (!in_string) begin
      wanted = tgt;
      unit_pos = 0;
      in_string = 1'b1;
    end
    if (held_n > 3) begin
      held_n = 3;
    end
    held[held_n] = b;
    held_n++;
    n = 0;
    while (held_n > 0 && n < 4) begin
      lead = held[0];
      need = lead_span(lead);
      take = 1;
      cp = {13'd0, lead};
      if (need > 1) begin
        have = (held_n < need) ? held_n : need;
        ok = 1'b1;
        for (int i = 1; i < have; i++) begin
          if ((held[i] & CONT_MASK) != CONT_TAG) begin
            ok = 1'b0;
          end
        end
        if (ok && held_n >= need) begin
          case (need)
            2: begin
              v = {10'd0, lead[4:0], held[1][5:0]};
              good = 1'b1;
            end
            3: begin
              v = {5'd0, lead[3:0], held[1][5:0], held[2][5:0]};
              good = v >= MIN_THREE && !(v >= SUR_LO && v <= SUR_HI);
            end
            default: begin
              v = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
              good = v >= MIN_FOUR && v <= MAX_CP;
            end
          endcase
          if (good) begin
            take = need;
            cp = v;
          end
        end else if (ok && !lst) begin
          break;
        end
      end
      predict_char(cp, take, lst && held_n == take);
      n++;
      for (int i = 0; i + take < held_n; i++) begin
        held[i] = held[i + take];
      end
      held_n -= take;
    end
    if (lst) begin
      held_n = 0;
      in_string = 1'b0;
      unit_pos = 0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      err_n++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    char_word_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        held[i] = '0;
      end
      held_n = 0;
      unit_pos = 0;
      wanted = 0;
      in_string = 1'b0;
      char_expect_q.delete();
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        predict_byte(byte_in.data_byte, byte_in.last_byte, byte_in.target_index);
      end
      if (char_out.valid && char_out.ready) begin
        if (char_expect_q.size() == 0) begin
          err_n++;
          $display("%0t: unexpected character word, expected none, actual code point 0x%0h",
                   $time, char_out.char_value);
        end else begin
          want = char_expect_q.pop_front();
          compare_field("char_value", want.char_value, char_out.char_value);
          compare_field("byte_width", want.byte_width, char_out.byte_width);
          compare_field("unit_count", want.unit_count, char_out.unit_count);
          compare_field("unit_offset", want.unit_offset, char_out.unit_offset);
          compare_field("hit", want.hit, char_out.hit);
          compare_field("hit_bytes", want.hit_bytes, char_out.hit_bytes);
          compare_field("hit_length", want.hit_length, char_out.hit_length);
          compare_field("total_units", want.total_units, char_out.total_units);
          compare_field("last_result", want.last_result, char_out.last_result);
          checked_n++;
          if (want.hit) begin
            hit_n++;
          end
        end
      end
    end
    mismatches <= err_n;
    chars_pending <= char_expect_q.size();
    chars_checked <= checked_n;
    hits_seen <= hit_n;
  end

endmodule

/* dv/utf8_to_utf16_unit_indexer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit indexer testbench
// Drives strings byte by byte: a few hand-picked strings first, then random
// strings that are mostly well-formed UTF-8 mixed with overlong, surrogate,
// out-of-range, truncated and raw bytes. The sender runs in bursts and the
// receiver stalls on its own pattern; the checker beside the block judges
// every word.
// ----------------------------------------------------------------------------
module utf8_to_utf16_unit_indexer_tb
  import u8u16_pkg::*;
();

  localparam int IW = INDEX_WIDTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_BYTES = 140;
  localparam logic [7:0] TWO_TAG = 8'hC0;
  localparam logic [7:0] SUR_LEAD = 8'hED;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8u16_in_if  byte_if ();
  u8u16_out_if char_if ();

  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned chars_checked;
  int unsigned hits_seen;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  bit          hold_req;
  logic [7:0]  text_q [$];

  always #5 clk = ~clk;

  utf8_to_utf16_unit_indexer i_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .char_out (char_if)
  );

  utf8_to_utf16_unit_indexer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_in       (byte_if),
    .char_out      (char_if),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked),
    .hits_seen     (hits_seen)
  );

  always @(posedge clk) begin
    if (rst || (byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
      $display("utf8_to_utf16_unit_indexer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver follows a random stall pattern that it redraws periodically.
  initial begin
    logic [15:0] stall_pattern;
    int unsigned phase;
    char_if.ready <= 1'b0;
    stall_pattern = '1;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        char_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom) & 16'($urandom);
            default: stall_pattern = 16'($urandom) | 16'($urandom);
          endcase
          if (stall_pattern == '0) begin
            stall_pattern = 16'h0001;
          end
        end
        char_if.ready <= stall_pattern[phase % 16];
        phase++;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [IW-1:0] tgt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= lst;
    byte_if.target_index <= tgt;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
  endtask

  // Target bits on bytes other than the first are ignored, so they are random.
  task automatic send_text(input logic [IW-1:0] tgt);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1, (i == 0) ? tgt : IW'($urandom));
    end
    text_q.delete();
    strings_sent++;
  endtask

  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  task automatic put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_q.push_back(TWO_TAG | {3'b000, cp[10:6]});
      text_q.push_back(CONT_TAG | {2'b00, cp[5:0]});
    end else if (cp < MIN_FOUR) begin
      text_q.push_back(THREE_TAG | {4'h0, cp[15:12]});
      text_q.push_back(CONT_TAG | {2'b00, cp[11:6]});
      text_q.push_back(CONT_TAG | {2'b00, cp[5:0]});
    end else begin
      text_q.push_back(LEAD4_LO | {5'd0, cp[20:18]});
      text_q.push_back(CONT_TAG | {2'b00, cp[17:12]});
      text_q.push_back(CONT_TAG | {2'b00, cp[11:6]});
      text_q.push_back(CONT_TAG | {2'b00, cp[5:0]});
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return CONT_TAG | 8'($urandom_range(0, 'h3F));
  endfunction

  task automatic put_random_char();
    logic [20:0] cp;
    int unsigned k;
    case ($urandom_range(0, 11))
      0, 1, 2: put_cp(21'($urandom_range(0, 'h7F)));
      3, 4: put_cp(21'($urandom_range('h80, 'h7FF)));
      5, 6: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= SUR_LO) begin
          cp += 21'h800;
        end
        put_cp(cp);
      end
      7, 8: put_cp(21'($urandom_range(MIN_FOUR, MAX_CP)));
      9: begin
        case ($urandom_range(0, 5))
          0: begin
            text_q.push_back(LEAD3_LO);
            text_q.push_back(CONT_TAG | 8'($urandom_range(0, 'h1F)));
            text_q.push_back(cont_byte());
          end
          1: begin
            text_q.push_back(SUR_LEAD);
            text_q.push_back(8'hA0 | 8'($urandom_range(0, 'h1F)));
            text_q.push_back(cont_byte());
          end
          2: begin
            text_q.push_back(LEAD4_HI);
            text_q.push_back(8'($urandom_range('h90, 'hBF)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
          3: begin
            text_q.push_back(LEAD4_LO);
            text_q.push_back(CONT_TAG | 8'($urandom_range(0, 'h0F)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
          4: begin
            text_q.push_back(TWO_TAG | 8'($urandom_range(0, 1)));
            text_q.push_back(cont_byte());
          end
          default: begin
            text_q.push_back(8'($urandom_range('hF5, 'hFF)));
            text_q.push_back(cont_byte());
          end
        endcase
      end
      10: begin
        k = $urandom_range(2, 4);
        case (k)
          2: put_cp(21'($urandom_range('h80, 'h7FF)));
          3: put_cp(21'($urandom_range('hE000, 'hFFFF)));
          default: put_cp(21'($urandom_range(MIN_FOUR, MAX_CP)));
        endcase
        repeat ($urandom_range(1, k - 1)) void'(text_q.pop_back());
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          text_q.push_back(8'($urandom));
        end else begin
          text_q.push_back(cont_byte());
        end
      end
    endcase
  endtask

  initial begin
    int unsigned base;
    int unsigned nchars;
    bit          held_off;
    bit          drained;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    byte_if.target_index <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    text_q = '{8'h00};
    send_text('0);
    text_q = '{8'hFF};
    send_text('1);
    text_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(IW'(2));
    // A bad fourth byte rejects the lead at once and releases four words.
    text_q = '{8'hF0, 8'h90, 8'h80, 8'h41};
    send_text(IW'(2));
    text_q = '{8'hE2, 8'h82};
    send_text(IW'(1));
    text_q = '{8'hED, 8'hA0, 8'h80};
    send_text(IW'(0));
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(IW'(3));

    base = bytes_sent;
    held_off = 1'b0;
    drained = 1'b0;
    while (bytes_sent - base < RANDOM_BYTES) begin
      nchars = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 6);
      repeat (nchars) put_random_char();
      if (!held_off && bytes_sent - base > RANDOM_BYTES / 3) begin
        hold_req = 1'b1;
        held_off = 1'b1;
      end
      if (!drained && bytes_sent - base > 2 * RANDOM_BYTES / 3) begin
        wait_drained();
        drained = 1'b1;
      end
      send_text(($urandom_range(0, 7) == 0) ? IW'($urandom)
                                            : IW'($urandom_range(0, 2 * nchars + 1)));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d strings in %0d bytes: hand-picked cases and random text with %s",
             strings_sent, bytes_sent, "overlong, surrogate, out-of-range and cut sequences.");
    $display("Checked %0d character words, %0d of them at the wanted index.",
             chars_checked, hits_seen);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_unit_indexer regression: pass");
    end else begin
      $display("utf8_to_utf16_unit_indexer regression: fail");
    end
    $finish;
  end

endmodule
